// ===== src/hkem_pkg.sv =====
// ----------------------------------------------------------------------------
// hkem_pkg
// Shared types, constants and key-mapping helpers for the hotkey matcher.
// ----------------------------------------------------------------------------
package hkem_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_W     = 8;
    localparam int MASK_W    = 4;
    localparam int NUM_KEYS  = 1 << KEY_W;

    // Slot binding layout
    localparam int SLOT_CTRL_BIT  = 8;
    localparam int SLOT_ALT_BIT   = 9;
    localparam int SLOT_SHIFT_BIT = 10;
    localparam int SLOT_EN_BIT    = 11;

    // Key codes with special meaning
    localparam logic [KEY_W-1:0] KEY_SHIFT  = 8'h10;
    localparam logic [KEY_W-1:0] KEY_CTRL   = 8'h11;
    localparam logic [KEY_W-1:0] KEY_ALT    = 8'h12;
    localparam logic [KEY_W-1:0] KEY_LSHIFT = 8'hA0;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 8'hA1;
    localparam logic [KEY_W-1:0] KEY_LCTRL  = 8'hA2;
    localparam logic [KEY_W-1:0] KEY_RCTRL  = 8'hA3;
    localparam logic [KEY_W-1:0] KEY_LALT   = 8'hA4;
    localparam logic [KEY_W-1:0] KEY_RALT   = 8'hA5;

    typedef enum logic [1:0] {
        CMD_KEY_DOWN   = 2'd0,
        CMD_KEY_UP     = 2'd1,
        CMD_MOUSE_DOWN = 2'd2,
        CMD_IGNORE     = 2'd3
    } cmd_t;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef slot_t [NUM_SLOTS-1:0] slot_array_t;

    // Event held between the front stage and the matcher
    typedef struct packed {
        logic             report;
        logic [KEY_W-1:0] key;
        logic             ctrl;
        logic             alt;
        logic             shift;
    } stage_t;

    function automatic logic is_modifier(input logic [KEY_W-1:0] k);
        return (k == KEY_SHIFT) || (k == KEY_CTRL) || (k == KEY_ALT) ||
               ((k >= KEY_LSHIFT) && (k <= KEY_RALT));
    endfunction

    // Left/right modifier codes fold onto their generic code
    function automatic logic [KEY_W-1:0] generic_of(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] g;
        case (k)
            KEY_LSHIFT, KEY_RSHIFT: g = KEY_SHIFT;
            KEY_LCTRL,  KEY_RCTRL:  g = KEY_CTRL;
            KEY_LALT,   KEY_RALT:   g = KEY_ALT;
            default:                g = k;
        endcase
        return g;
    endfunction

endpackage

// ===== src/hkem_event_if.sv =====
// ----------------------------------------------------------------------------
// hkem_event_if
// Valid/ready channel carrying one keyboard or mouse event per beat.
// ----------------------------------------------------------------------------
interface hkem_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] key_code;
    logic       ctrl_down;
    logic       alt_down;
    logic       shift_down;
    logic       target_focused;

    modport source (
        output valid, command, key_code, ctrl_down, alt_down, shift_down,
               target_focused,
        input  ready
    );

    modport sink (
        input  valid, command, key_code, ctrl_down, alt_down, shift_down,
               target_focused,
        output ready
    );
endinterface

// ===== src/hkem_result_if.sv =====
// ----------------------------------------------------------------------------
// hkem_result_if
// Valid/ready channel carrying one match result per beat.
// ----------------------------------------------------------------------------
interface hkem_result_if;
    logic       valid;
    logic       ready;
    logic       fired;
    logic [3:0] match_mask;

    modport source (
        output valid, fired, match_mask,
        input  ready
    );

    modport sink (
        input  valid, fired, match_mask,
        output ready
    );
endinterface

// ===== src/hkem_front.sv =====
// ----------------------------------------------------------------------------
// hkem_front
// Input stage: held-key map update and report decision, registered event.
// ----------------------------------------------------------------------------
module hkem_front
    import hkem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hkem_event_if.sink   evt,
    input  logic         take,      // matcher takes the stage this cycle
    output logic         s1_valid,
    output stage_t       s1_data
);

    logic [NUM_KEYS-1:0] held_reg;
    logic [NUM_KEYS-1:0] held_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    stage_t              s1_data_reg;
    logic                report;
    logic                accept;

    assign evt.ready = !s1_valid_reg || take;
    assign accept    = evt.valid && evt.ready;

    always_comb
    begin
        held_next = held_reg;
        report    = 1'b0;
        unique case (cmd_t'(evt.command))
            CMD_KEY_DOWN:
            begin
                if (!held_reg[evt.key_code])
                begin
                    held_next[evt.key_code] = 1'b1;
                    report                  = evt.target_focused;
                end
            end
            CMD_KEY_UP:
            begin
                held_next[evt.key_code] = 1'b0;
            end
            CMD_MOUSE_DOWN:
            begin
                report = evt.target_focused;
            end
            CMD_IGNORE:
            begin
                report = 1'b0;
            end
        endcase
    end

    assign s1_valid_next = accept || (s1_valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg.report <= report;
            s1_data_reg.key    <= evt.key_code;
            s1_data_reg.ctrl   <= evt.ctrl_down;
            s1_data_reg.alt    <= evt.alt_down;
            s1_data_reg.shift  <= evt.shift_down;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

`ifndef SYNTHESIS
    a_down_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (evt.command == CMD_KEY_DOWN) |=> held_reg[$past(evt.key_code)])
        else $error("key down did not mark key held");

    a_up_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (evt.command == CMD_KEY_UP) |=> !held_reg[$past(evt.key_code)])
        else $error("key up did not release key");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !take |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("stalled event lost or changed");
`endif

endmodule

// ===== src/hkem_match.sv =====
// ----------------------------------------------------------------------------
// hkem_match
// Parallel slot compare and registered result.
// ----------------------------------------------------------------------------
module hkem_match
    import hkem_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s1_valid,
    input  stage_t        s1_data,
    input  slot_array_t   slots,
    output logic          take,
    hkem_result_if.source res
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              fired_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [KEY_W-1:0]  gen_key;

    assign take    = s1_valid && (!out_valid_reg || res.ready);
    assign gen_key = generic_of(s1_data.key);

    always_comb
    begin
        logic [KEY_W-1:0] bk;
        logic             key_hit;
        logic             mod_hit;
        mask_next = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            bk      = slots[i][KEY_W-1:0];
            key_hit = (bk == s1_data.key) || (bk == gen_key);
            mod_hit = is_modifier(bk) ||
                      ((slots[i][SLOT_CTRL_BIT]  == s1_data.ctrl) &&
                       (slots[i][SLOT_ALT_BIT]   == s1_data.alt) &&
                       (slots[i][SLOT_SHIFT_BIT] == s1_data.shift));
            if (i < MASK_W)
            begin
                mask_next[i] = s1_data.report && slots[i][SLOT_EN_BIT] &&
                               key_hit && mod_hit;
            end
        end
    end

    assign out_valid_next = take || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fired_reg <= s1_data.report;
            mask_reg  <= mask_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.fired      = fired_reg;
    assign res.match_mask = mask_reg;

`ifndef SYNTHESIS
    a_mask_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !fired_reg |-> (mask_reg == '0))
        else $error("match mask set on unreported event");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("taken event produced no result");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=>
            out_valid_reg && $stable(fired_reg) && $stable(mask_reg))
        else $error("stalled result lost or changed");
`endif

endmodule

// ===== src/hotkey_event_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// hotkey_event_matcher_unit
// Hotkey matcher: held-key filter plus compare against four slot bindings.
// ----------------------------------------------------------------------------
// Usage:
//   evt  : valid/ready sink, one key/mouse event per beat.
//   res  : valid/ready source, exactly one result beat per event beat.
//   cfg  : write port (cfg_wr_en, cfg_index, cfg_wdata); write slot
//          bindings only while no event is in flight.
// Pipeline: an accepted event passes the input register, then the compare
//   into the result register, from which its result beat goes out.
// Throughput: one event per cycle while res.ready is high; the held-key
//   map is read and updated in the accept cycle, so back-to-back events on
//   the same key see each other's update.
// Reset: held-key map cleared (no key held), all slots disabled, both
//   pipeline registers empty. evt.ready is high right after reset.
// Stall: when res.ready is low the result register holds, the input
//   register fills behind it, and evt.ready drops once both are full.
//   Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hotkey_event_matcher_unit
    import hkem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hkem_event_if.sink           evt,
    hkem_result_if.source        res,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SLOT_W-1:0]    cfg_wdata
);

    // Slot binding registers, one per slot
    slot_array_t slot_reg;
    logic        take;
    logic        s1_valid;
    stage_t      s1_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    slot_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Held-key filter and input register
    hkem_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    // Slot compare and result register
    hkem_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .slots    (slot_reg),
        .take     (take),
        .res      (res)
    );

endmodule

// ===== tb/hkem_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkem_match_checker
// Watches the event, result and config ports of the hotkey matcher and
// predicts each result beat from its own copy of the held-key map and slot
// bindings. Result beats are compared in order against those predictions.
// ----------------------------------------------------------------------------
module hkem_match_checker
    import hkem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hkem_event_if                evt,
    hkem_result_if               res,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SLOT_W-1:0]    cfg_wdata,
    output int                   mismatches,
    output int                   pending
);

    typedef struct packed {
        logic              fired;
        logic [MASK_W-1:0] mask;
    } outcome_t;

    slot_t               bindings [NUM_SLOTS];
    logic [NUM_KEYS-1:0] held;
    outcome_t            outcomes_due [$];
    int                  error_count = 0;
    int                  due_count   = 0;

    assign mismatches = error_count;
    assign pending    = due_count;

    // Left/right codes fold onto the generic modifier code
    function automatic logic [KEY_W-1:0] side_to_generic(input logic [KEY_W-1:0] k);
        if (k == KEY_LSHIFT || k == KEY_RSHIFT)
            return KEY_SHIFT;
        if (k == KEY_LCTRL || k == KEY_RCTRL)
            return KEY_CTRL;
        if (k == KEY_LALT || k == KEY_RALT)
            return KEY_ALT;
        return k;
    endfunction

    function automatic logic modifier_key(input logic [KEY_W-1:0] k);
        return k == KEY_SHIFT || k == KEY_CTRL || k == KEY_ALT ||
               (k >= KEY_LSHIFT && k <= KEY_RALT);
    endfunction

    function automatic logic [MASK_W-1:0] slot_hits(input logic [KEY_W-1:0] key,
                                                    input logic [2:0] levels);
        logic [MASK_W-1:0] hits;
        slot_t             b;
        logic [KEY_W-1:0]  bk;
        hits = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            b  = bindings[i];
            bk = b[KEY_W-1:0];
            // a bound modifier key matches whatever the levels are
            if (b[SLOT_EN_BIT] && (bk == key || bk == side_to_generic(key)) &&
                (modifier_key(bk) ||
                 {b[SLOT_CTRL_BIT], b[SLOT_ALT_BIT], b[SLOT_SHIFT_BIT]} == levels))
                hits[i] = 1'b1;
        end
        return hits;
    endfunction

    // Updates the held-key map and returns the result the beat must produce
    function automatic outcome_t resolve_event(input cmd_t cmd,
                                               input logic [KEY_W-1:0] key,
                                               input logic [2:0] levels,
                                               input logic focus);
        outcome_t o;
        logic     report;
        report = 1'b0;
        case (cmd)
            CMD_KEY_DOWN:
                if (!held[key])
                begin
                    held[key] = 1'b1;
                    report    = focus;
                end
            CMD_KEY_UP:     held[key] = 1'b0;
            CMD_MOUSE_DOWN: report = focus;
            default:        ;
        endcase
        o.fired = report;
        o.mask  = report ? slot_hits(key, levels) : '0;
        return o;
    endfunction

    // Appends one predicted result at the tail of the due list
    function automatic void enqueue_due(input outcome_t o);
        outcomes_due.insert(outcomes_due.size(), o);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            held = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                bindings[i] = '0;
            outcomes_due.delete();
        end
        else
        begin
            if (cfg_wr_en && cfg_index < NUM_SLOTS)
                bindings[cfg_index] = cfg_wdata;

            if (evt.valid && evt.ready)
                enqueue_due(resolve_event(cmd_t'(evt.command), evt.key_code,
                                          {evt.ctrl_down, evt.alt_down,
                                           evt.shift_down},
                                          evt.target_focused));

            if (res.valid && res.ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing due: fired=%0b mask=%h",
                             $time, res.fired, res.match_mask);
                    error_count++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (res.fired !== want.fired)
                    begin
                        $display("%0t: fired: expected %0b, got %0b",
                                 $time, want.fired, res.fired);
                        error_count++;
                    end
                    else if (res.match_mask !== want.mask)
                    begin
                        $display("%0t: match_mask: expected %h, got %h",
                                 $time, want.mask, res.match_mask);
                        error_count++;
                    end
                end
            end
        end
        due_count = outcomes_due.size();
    end

endmodule

// ===== tb/hotkey_event_matcher_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotkey_event_matcher_unit_tb
// Drives key, mouse and ignored events into the hotkey matcher over four
// phases of slot bindings and handshake pressure. The checker beside the
// block predicts every result beat; this module only makes stimulus,
// watches for a hang and gives the verdict.
// ----------------------------------------------------------------------------
module hotkey_event_matcher_unit_tb;
    import hkem_pkg::*;

    localparam int CLK_HALF        = 4;     // 8 ns period
    localparam int RESET_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 432;   // four phases, ~1750 beats in all
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no beat on any channel
    localparam int FLUSH_CYCLES    = 4;     // result shows behind the input and result registers

    // Modifier levels, packed {ctrl, alt, shift}
    localparam logic [2:0] LVL_NONE = 3'b000;
    localparam logic [2:0] LVL_CTRL = 3'b100;
    localparam logic [2:0] LVL_ALL  = 3'b111;

    localparam logic [KEY_W-1:0] KEY_A = 8'h41;

    localparam logic [KEY_W-1:0] MOD_KEYS [9] = '{KEY_SHIFT, KEY_CTRL, KEY_ALT,
                                                 KEY_LSHIFT, KEY_RSHIFT, KEY_LCTRL,
                                                 KEY_RCTRL, KEY_LALT, KEY_RALT};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SLOT_W-1:0]    cfg_wdata;
    int                   mismatches;
    int                   pending;

    // Handshake pressure, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    // Bindings as last written, used only to steer the random events
    slot_t slot_cfg [NUM_SLOTS];

    hkem_event_if  evt_ch ();
    hkem_result_if res_ch ();

    hotkey_event_matcher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    hkem_match_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt_ch),
        .res        (res_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Result side: ready redrawn every falling edge
    always @(negedge clk)
        res_ch.ready = ($urandom_range(0, 99) >= stall_pct);

    // Hang detector: any beat on either channel resets the count
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic slot_t make_binding(input logic en, input logic [2:0] levels,
                                           input logic [KEY_W-1:0] key);
        slot_t b;
        b                 = '0;
        b[KEY_W-1:0]      = key;
        b[SLOT_CTRL_BIT]  = levels[2];
        b[SLOT_ALT_BIT]   = levels[1];
        b[SLOT_SHIFT_BIT] = levels[0];
        b[SLOT_EN_BIT]    = en;
        return b;
    endfunction

    // Mostly modifiers and a few letters, so slots overlap and fold onto each other
    function automatic slot_t random_binding();
        int               r;
        logic [KEY_W-1:0] key;
        r = $urandom_range(0, 99);
        if (r < 45)
            key = MOD_KEYS[$urandom_range(0, 8)];
        else if (r < 75)
            key = KEY_A + 8'($urandom_range(0, 2));
        else
            key = 8'($urandom_range(0, 255));
        return make_binding($urandom_range(0, 99) < 85, 3'($urandom_range(0, 7)), key);
    endfunction

    // Called right after a falling edge; returns right after the falling edge that
    // follows acceptance. valid is left high so back-to-back beats need no toggle.
    task automatic send_event(input cmd_t cmd, input logic [KEY_W-1:0] key,
                              input logic [2:0] levels, input logic focus);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            evt_ch.valid = 1'b0;
            @(negedge clk);
        end
        evt_ch.valid          = 1'b1;
        evt_ch.command        = cmd;
        evt_ch.key_code       = key;
        evt_ch.ctrl_down      = levels[2];
        evt_ch.alt_down       = levels[1];
        evt_ch.shift_down     = levels[0];
        evt_ch.target_focused = focus;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_slot(input int idx, input slot_t value);
        cfg_wr_en     = 1'b1;
        cfg_index     = idx[CFG_IDX_W-1:0];
        cfg_wdata     = value;
        @(negedge clk);
        cfg_wr_en     = 1'b0;
        slot_cfg[idx] = value;
    endtask

    // Sender holds off until every result is back; bindings change only after a drain or before the first event
    task automatic drain();
        evt_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic random_events(input int count);
        int               r;
        slot_t            b;
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [2:0]       levels;
        repeat (count)
        begin
            b = slot_cfg[$urandom_range(0, NUM_SLOTS-1)];
            // key: bound key, a side/generic modifier, or anything
            r = $urandom_range(0, 99);
            if (r < 40)
                key = b[KEY_W-1:0];
            else if (r < 60)
                key = MOD_KEYS[$urandom_range(0, 8)];
            else
                key = 8'($urandom_range(0, 255));
            // down/up dominate so keys keep cycling through the held map
            r = $urandom_range(0, 99);
            if (r < 40)
                cmd = CMD_KEY_DOWN;
            else if (r < 75)
                cmd = CMD_KEY_UP;
            else if (r < 90)
                cmd = CMD_MOUSE_DOWN;
            else
                cmd = CMD_IGNORE;
            if ($urandom_range(0, 99) < 60)
                levels = {b[SLOT_CTRL_BIT], b[SLOT_ALT_BIT], b[SLOT_SHIFT_BIT]};
            else
                levels = 3'($urandom_range(0, 7));
            send_event(cmd, key, levels, $urandom_range(0, 99) < 85);
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        evt_ch.valid          = 1'b0;
        evt_ch.command        = CMD_IGNORE;
        evt_ch.key_code       = '0;
        evt_ch.ctrl_down      = 1'b0;
        evt_ch.alt_down       = 1'b0;
        evt_ch.shift_down     = 1'b0;
        evt_ch.target_focused = 1'b0;
        res_ch.ready          = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_cfg[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- Phase 1: no idling, directed bindings and special cases ---
        send_idle_pct = 0;
        stall_pct     = 0;
        write_slot(0, make_binding(1'b1, LVL_CTRL, KEY_A));      // Ctrl+A
        write_slot(1, make_binding(1'b1, LVL_NONE, KEY_SHIFT));  // generic shift
        write_slot(2, make_binding(1'b1, LVL_ALL,  KEY_LCTRL));  // left ctrl, levels ignored
        write_slot(3, make_binding(1'b1, LVL_NONE, KEY_A));      // plain A

        send_event(CMD_KEY_DOWN,   KEY_A, LVL_CTRL, 1'b1);   // first press: slot 0
        send_event(CMD_KEY_DOWN,   KEY_A, LVL_CTRL, 1'b1);   // auto-repeat, silent
        send_event(CMD_KEY_UP,     KEY_A, LVL_CTRL, 1'b1);
        send_event(CMD_KEY_UP,     KEY_A, LVL_CTRL, 1'b1);   // release of a free key
        send_event(CMD_KEY_DOWN,   KEY_A, LVL_NONE, 1'b1);   // slot 3
        send_event(CMD_KEY_UP,     KEY_A, LVL_NONE, 1'b1);
        send_event(CMD_KEY_DOWN,   KEY_A, LVL_NONE, 1'b0);   // unfocused still marks held
        send_event(CMD_KEY_DOWN,   KEY_A, LVL_NONE, 1'b1);   // so this one is silent
        send_event(CMD_KEY_UP,     KEY_A, LVL_NONE, 1'b1);
        send_event(CMD_KEY_DOWN,   KEY_LSHIFT, LVL_ALL, 1'b1);   // folds to shift
        send_event(CMD_KEY_DOWN,   KEY_RSHIFT, LVL_ALL, 1'b1);
        send_event(CMD_KEY_DOWN,   KEY_SHIFT,  LVL_ALL, 1'b1);   // exact generic
        send_event(CMD_KEY_DOWN,   KEY_LCTRL,  LVL_NONE, 1'b1);  // exact side key
        send_event(CMD_KEY_DOWN,   KEY_RCTRL,  LVL_ALL, 1'b1);   // other side: no hit
        send_event(CMD_MOUSE_DOWN, KEY_A, LVL_CTRL, 1'b1);   // mouse skips held map
        send_event(CMD_MOUSE_DOWN, KEY_A, LVL_CTRL, 1'b1);
        send_event(CMD_MOUSE_DOWN, KEY_A, LVL_CTRL, 1'b0);   // unfocused mouse
        send_event(CMD_IGNORE,     KEY_A, LVL_CTRL, 1'b1);
        send_event(CMD_KEY_DOWN,   8'hFF, LVL_ALL,  1'b1);
        send_event(CMD_KEY_DOWN,   8'h00, LVL_NONE, 1'b1);
        send_event(CMD_KEY_UP,     KEY_LSHIFT, LVL_NONE, 1'b1);
        send_event(CMD_KEY_UP,     KEY_RSHIFT, LVL_NONE, 1'b1);
        send_event(CMD_KEY_UP,     KEY_SHIFT,  LVL_NONE, 1'b1);
        send_event(CMD_KEY_UP,     KEY_LCTRL,  LVL_NONE, 1'b1);
        random_events(ITEMS_PER_PHASE);
        drain();

        // --- Phase 2: sender mostly idle; extreme binding values ---
        send_idle_pct = 86;
        stall_pct     = 0;
        write_slot(0, make_binding(1'b1, LVL_ALL,  8'hFF));  // all ones
        write_slot(1, make_binding(1'b0, LVL_ALL,  8'hFF));  // disabled, rest set
        write_slot(2, make_binding(1'b1, LVL_NONE, 8'h00));
        write_slot(3, make_binding(1'b1, LVL_NONE, KEY_ALT));
        random_events(ITEMS_PER_PHASE);
        drain();

        // --- Phase 3: receiver mostly stalled; random bindings ---
        send_idle_pct = 0;
        stall_pct     = 86;
        for (int i = 0; i < NUM_SLOTS; i++)
            write_slot(i, random_binding());
        random_events(ITEMS_PER_PHASE);
        drain();

        // --- Phase 4: both sides idle now and then; one slot back to all zero ---
        send_idle_pct = 23;
        stall_pct     = 23;
        for (int i = 0; i < NUM_SLOTS - 1; i++)
            write_slot(i, random_binding());
        write_slot(NUM_SLOTS - 1, '0);
        random_events(ITEMS_PER_PHASE);

        // all beats in; wait for every result, then let the pipeline settle
        evt_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
